### sv/nbl_pkg.sv
// Package for the bench netlist lexer: token kinds, lexer modes, keyword tables
// and the structs passed between the lexer core and the result queue.
// Depends on nothing.
package nbl_pkg;

    typedef logic [4:0] t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_WORD    = 2'd2
    } t_mode;

    localparam t_kind KIND_EOF    = 5'd0;
    localparam t_kind KIND_EQUAL  = 5'd1;
    localparam t_kind KIND_LPAREN = 5'd2;
    localparam t_kind KIND_RPAREN = 5'd3;
    localparam t_kind KIND_COMMA  = 5'd4;
    localparam t_kind KIND_NAME   = 5'd16;
    localparam t_kind KIND_TEXT   = 5'd17;

    localparam int NUM_KW     = 12;
    localparam int KW_MAX_LEN = 6;

    localparam logic [NUM_KW-1:0] ALIVE_ALL = '1;
    localparam logic [2:0]        LEN_MAX   = 3'd7;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Keyword spellings, one character per slot, unused slots zero.
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{"I", "N", "P", "U", "T", 8'h00},
        '{"O", "U", "T", "P", "U", "T"},
        '{"B", "U", "F", "F", 8'h00, 8'h00},
        '{"N", "O", "T", 8'h00, 8'h00, 8'h00},
        '{"I", "N", "V", 8'h00, 8'h00, 8'h00},
        '{"A", "N", "D", 8'h00, 8'h00, 8'h00},
        '{"N", "A", "N", "D", 8'h00, 8'h00},
        '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"N", "O", "R", 8'h00, 8'h00, 8'h00},
        '{"X", "O", "R", 8'h00, 8'h00, 8'h00},
        '{"X", "N", "O", "R", 8'h00, 8'h00},
        '{"D", "F", "F", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd5, 3'd6, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3
    };

    // INV shares the NOT token.
    localparam t_kind KW_KIND [NUM_KW] = '{
        5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] text;
        logic       last;
    } t_result;

    // Up to two results produced by one accepted character.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_EQUAL:  k = KIND_EQUAL;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_COMMA:  k = KIND_COMMA;
            default:   k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

endpackage

### sv/netlist_bench_lexer.sv
// Top level of the bench netlist lexer: lexer core feeding a result queue.
// Depends on nbl_pkg, nbl_core and nbl_res_fifo.
//
//  channel  | dir | tdata           | tuser            | tlast
//  ---------+-----+-----------------+------------------+-------------
//  s (in)   | in  | [7:0] char_in   | -                | at_end
//  m (out)  | out | [7:0] text_byte | [4:0] token_kind | last_of_run
//
// Each character is lexed in the cycle it is accepted; its one or two results
// enter the result queue and reach the master side from the next cycle on.
// The slave side takes one request per cycle while the queue has room for two
// results; results leave one per cycle, so two-result characters back to back
// are bounded by the master side. Reset (synchronous, active low) empties the
// queue and puts the lexer between tokens; a stalled master side fills the queue.
module netlist_bench_lexer #(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [7:0]  i_tdata,   // [7:0] char_in
    input  logic        i_tlast,   // at_end
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [7:0]  o_tdata,   // [7:0] text_byte
    output logic [4:0]  o_tuser,   // [4:0] token_kind
    output logic        o_tlast    // last_of_run
);

    logic             in_accept;
    logic             out_pop;
    logic             fifo_room;
    nbl_pkg::t_push   push;
    nbl_pkg::t_result head;

    assign o_tready  = fifo_room;
    assign in_accept = i_tvalid && fifo_room;
    assign out_pop   = o_tvalid && i_tready;

    nbl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (i_tdata),
        .i_end    (i_tlast),
        .o_push   (push)
    );

    nbl_res_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_head  (head),
        .o_valid (o_tvalid),
        .o_room  (fifo_room)
    );

    assign o_tdata = head.text;
    assign o_tuser = head.kind;
    assign o_tlast = head.last;

`ifndef NO_ASSERTIONS
    a_text_only_on_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && (o_tuser != nbl_pkg::KIND_TEXT)) |-> (o_tdata == 8'h00))
        else $error("text byte set on a token that is not a word character");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> (o_tuser <= nbl_pkg::KIND_TEXT))
        else $error("token kind out of range");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && (o_tuser == nbl_pkg::KIND_EOF)) |-> o_tlast)
        else $error("end-of-file token not marked last");
`endif

endmodule

### sv/nbl_core.sv
// Lexer core: mode, keyword prefix mask and word length, and the results
// produced by each accepted character. Depends on nbl_pkg.
module nbl_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char,
    input  logic           i_end,
    output nbl_pkg::t_push o_push
);

    nbl_pkg::t_mode            r_mode,  n_mode;
    logic [nbl_pkg::NUM_KW-1:0] r_alive, n_alive;
    logic [2:0]                r_len,   n_len;

    logic [nbl_pkg::NUM_KW-1:0] base_alive, add_alive;
    logic [2:0]                base_len,   add_len;
    nbl_pkg::t_kind            close_kind;
    nbl_pkg::t_kind            p_kind;
    logic                      is_punct;
    logic                      is_delim;
    nbl_pkg::t_push            push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= nbl_pkg::MODE_IDLE;
            r_alive <= nbl_pkg::ALIVE_ALL;
            r_len   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_alive <= n_alive;
            r_len   <= n_len;
        end
    end

    // Keyword mask after one more word character; a new word starts fresh.
    always_comb begin
        base_alive = (r_mode == nbl_pkg::MODE_WORD) ? r_alive : nbl_pkg::ALIVE_ALL;
        base_len   = (r_mode == nbl_pkg::MODE_WORD) ? r_len : 3'd0;
        add_alive  = base_alive;
        for (int k = 0; k < nbl_pkg::NUM_KW; k++) begin
            if (base_len >= nbl_pkg::KW_LEN[k]) begin
                add_alive[k] = 1'b0;
            end else if (nbl_pkg::KW_TEXT[k][base_len] != i_char) begin
                add_alive[k] = 1'b0;
            end
        end
        add_len = (base_len == nbl_pkg::LEN_MAX) ? base_len : base_len + 3'd1;
    end

    // Closing token: the lowest keyword still alive whose length matches.
    always_comb begin
        close_kind = nbl_pkg::KIND_NAME;
        for (int k = nbl_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_alive[k] && (r_len == nbl_pkg::KW_LEN[k])) begin
                close_kind = nbl_pkg::KW_KIND[k];
            end
        end
    end

    always_comb begin
        p_kind   = nbl_pkg::punct_kind(i_char);
        is_punct = (p_kind != nbl_pkg::KIND_EOF);
        is_delim = is_punct || nbl_pkg::is_space(i_char) || (i_char == nbl_pkg::CH_HASH);
    end

    // Next state.
    always_comb begin
        n_mode  = r_mode;
        n_alive = r_alive;
        n_len   = r_len;
        if (i_end) begin
            n_mode  = nbl_pkg::MODE_IDLE;
            n_alive = nbl_pkg::ALIVE_ALL;
            n_len   = '0;
        end else begin
            unique case (r_mode)
                nbl_pkg::MODE_COMMENT: begin
                    if (i_char == nbl_pkg::CH_NL) begin
                        n_mode = nbl_pkg::MODE_IDLE;
                    end
                end
                nbl_pkg::MODE_WORD: begin
                    if (is_delim) begin
                        n_alive = nbl_pkg::ALIVE_ALL;
                        n_len   = '0;
                        n_mode  = (i_char == nbl_pkg::CH_HASH) ? nbl_pkg::MODE_COMMENT
                                                               : nbl_pkg::MODE_IDLE;
                    end else begin
                        n_alive = add_alive;
                        n_len   = add_len;
                    end
                end
                default: begin
                    n_mode = nbl_pkg::MODE_IDLE;
                    if (nbl_pkg::is_space(i_char)) begin
                        n_mode = nbl_pkg::MODE_IDLE;
                    end else if (i_char == nbl_pkg::CH_HASH) begin
                        n_mode = nbl_pkg::MODE_COMMENT;
                    end else if (!is_punct) begin
                        n_alive = add_alive;
                        n_len   = add_len;
                        n_mode  = nbl_pkg::MODE_WORD;
                    end
                end
            endcase
        end
    end

    // Results of the accepted character.
    always_comb begin
        push = '0;
        if (i_end) begin
            if (r_mode == nbl_pkg::MODE_WORD) begin
                push.count = 2'd2;
                push.r0    = '{kind: close_kind, text: 8'h00, last: 1'b0};
                push.r1    = '{kind: nbl_pkg::KIND_EOF, text: 8'h00, last: 1'b1};
            end else begin
                push.count = 2'd1;
                push.r0    = '{kind: nbl_pkg::KIND_EOF, text: 8'h00, last: 1'b1};
            end
        end else begin
            unique case (r_mode)
                nbl_pkg::MODE_COMMENT: begin
                    push = '0;
                end
                nbl_pkg::MODE_WORD: begin
                    if (is_delim) begin
                        if (is_punct) begin
                            push.count = 2'd2;
                            push.r0    = '{kind: close_kind, text: 8'h00, last: 1'b0};
                            push.r1    = '{kind: p_kind, text: 8'h00, last: 1'b1};
                        end else begin
                            push.count = 2'd1;
                            push.r0    = '{kind: close_kind, text: 8'h00, last: 1'b1};
                        end
                    end else begin
                        push.count = 2'd1;
                        push.r0    = '{kind: nbl_pkg::KIND_TEXT, text: i_char, last: 1'b1};
                    end
                end
                default: begin
                    if (nbl_pkg::is_space(i_char) || (i_char == nbl_pkg::CH_HASH)) begin
                        push = '0;
                    end else if (is_punct) begin
                        push.count = 2'd1;
                        push.r0    = '{kind: p_kind, text: 8'h00, last: 1'b1};
                    end else begin
                        push.count = 2'd1;
                        push.r0    = '{kind: nbl_pkg::KIND_TEXT, text: i_char, last: 1'b1};
                    end
                end
            endcase
        end
        if (!i_accept) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end) |=> (r_mode == nbl_pkg::MODE_IDLE) && (r_len == 3'd0)
                                && (r_alive == nbl_pkg::ALIVE_ALL))
        else $error("end marker did not return the lexer to idle");
    a_idle_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != nbl_pkg::MODE_WORD) |-> (r_len == 3'd0) && (r_alive == nbl_pkg::ALIVE_ALL))
        else $error("word state left over outside a word");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (!o_push.r0.last && o_push.r1.last))
        else $error("last flag misplaced on a two-result request");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd3) && ((o_push.count == 2'd0) || i_accept))
        else $error("result count without an accepted character");
`endif

endmodule

### sv/nbl_res_fifo.sv
// Result queue: takes up to two results per cycle from the lexer core and
// hands them out one per cycle as they are taken. Depends on nbl_pkg.
module nbl_res_fifo #(
    parameter int P_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nbl_pkg::t_push   i_push,
    input  logic             i_pop,
    output nbl_pkg::t_result o_head,
    output logic             o_valid,
    output logic             o_room
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(P_DEPTH - 2);

    nbl_pkg::t_result mem [P_DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [PTR_W-1:0] wr_ptr1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr1  = ptr_inc(r_wr_ptr);
        n_wr_ptr = r_wr_ptr;
        if (i_push.count == 2'd1) begin
            n_wr_ptr = wr_ptr1;
        end else if (i_push.count == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.count) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            mem[wr_ptr1] <= i_push.r1;
        end
    end

    assign o_head  = mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CNT_ROOM);

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(P_DEPTH))
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("results written without room for two");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("result read from an empty queue");
`endif

endmodule

### dv/testbench.sv
// Self-checking bench for netlist_bench_lexer: streams bench-format text into the lexer,
// predicts every token in-line and checks each one as it leaves the master side.
// Depends on nbl_pkg and the lexer RTL.
module testbench;

    localparam int HOLD_CYCLES  = 200;
    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_tvalid;
    logic        o_tready;
    logic [7:0]  i_tdata;   // [7:0] char_in
    logic        i_tlast;   // at_end
    logic        o_tvalid;
    logic        i_tready;
    logic [7:0]  o_tdata;   // [7:0] text_byte
    logic [4:0]  o_tuser;   // [4:0] token_kind
    logic        o_tlast;   // last_of_run

    // Lexer state as the bench sees it.
    nbl_pkg::t_mode             lex_state;
    logic [nbl_pkg::NUM_KW-1:0] kw_live;
    logic [2:0]                 word_len;

    nbl_pkg::t_result pending_tokens[$];
    logic [7:0]       text_buf[$];

    bit idle_gaps;
    bit long_hold;
    int n_sent;
    int n_checked;
    int n_eof;
    int n_keywords;
    int n_errors;

    netlist_bench_lexer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .o_tready (o_tready),
        .i_tdata  (i_tdata),
        .i_tlast  (i_tlast),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_tdata  (o_tdata),
        .o_tuser  (o_tuser),
        .o_tlast  (o_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void restart_word();
        kw_live  = nbl_pkg::ALIVE_ALL;
        word_len = 3'd0;
    endfunction

    function automatic void grow_word(input logic [7:0] c);
        for (int i = 0; i < nbl_pkg::NUM_KW; i++) begin
            if (word_len >= nbl_pkg::KW_LEN[i]) begin
                kw_live[i] = 1'b0;
            end else if (nbl_pkg::KW_TEXT[i][word_len] != c) begin
                kw_live[i] = 1'b0;
            end
        end
        if (word_len != nbl_pkg::LEN_MAX) begin
            word_len = word_len + 3'd1;
        end
    endfunction

    // The lowest-numbered keyword still matching at full length wins.
    function automatic nbl_pkg::t_kind word_token();
        nbl_pkg::t_kind k;
        k = nbl_pkg::KIND_NAME;
        for (int i = nbl_pkg::NUM_KW - 1; i >= 0; i--) begin
            if (kw_live[i] && nbl_pkg::KW_LEN[i] == word_len) begin
                k = nbl_pkg::KW_KIND[i];
            end
        end
        return k;
    endfunction

    function automatic void lex_predict(input logic [7:0] c, input logic at_end);
        nbl_pkg::t_result tok [2];
        int               n;
        nbl_pkg::t_kind   dk;
        logic             blank;
        n = 0;
        case (c)
            nbl_pkg::CH_EQUAL:  dk = nbl_pkg::KIND_EQUAL;
            nbl_pkg::CH_LPAREN: dk = nbl_pkg::KIND_LPAREN;
            nbl_pkg::CH_RPAREN: dk = nbl_pkg::KIND_RPAREN;
            nbl_pkg::CH_COMMA:  dk = nbl_pkg::KIND_COMMA;
            default:            dk = nbl_pkg::KIND_EOF;
        endcase
        blank = (c == nbl_pkg::CH_SPACE) || (c == nbl_pkg::CH_TAB) || (c == nbl_pkg::CH_NL);
        if (at_end) begin
            if (lex_state == nbl_pkg::MODE_WORD) begin
                tok[n] = '{word_token(), 8'h00, 1'b0};
                n++;
            end
            tok[n] = '{nbl_pkg::KIND_EOF, 8'h00, 1'b0};
            n++;
            lex_state = nbl_pkg::MODE_IDLE;
            restart_word();
        end else if (lex_state == nbl_pkg::MODE_COMMENT) begin
            if (c == nbl_pkg::CH_NL) begin
                lex_state = nbl_pkg::MODE_IDLE;
            end
        end else if (lex_state == nbl_pkg::MODE_WORD) begin
            if (dk != nbl_pkg::KIND_EOF || blank || c == nbl_pkg::CH_HASH) begin
                tok[n] = '{word_token(), 8'h00, 1'b0};
                n++;
                restart_word();
                if (dk != nbl_pkg::KIND_EOF) begin
                    tok[n] = '{dk, 8'h00, 1'b0};
                    n++;
                end
                if (c == nbl_pkg::CH_HASH) begin
                    lex_state = nbl_pkg::MODE_COMMENT;
                end else begin
                    lex_state = nbl_pkg::MODE_IDLE;
                end
            end else begin
                grow_word(c);
                tok[n] = '{nbl_pkg::KIND_TEXT, c, 1'b0};
                n++;
            end
        end else begin
            if (blank) begin
                lex_state = nbl_pkg::MODE_IDLE;
            end else if (c == nbl_pkg::CH_HASH) begin
                lex_state = nbl_pkg::MODE_COMMENT;
            end else if (dk != nbl_pkg::KIND_EOF) begin
                tok[n] = '{dk, 8'h00, 1'b0};
                n++;
                lex_state = nbl_pkg::MODE_IDLE;
            end else begin
                restart_word();
                grow_word(c);
                tok[n] = '{nbl_pkg::KIND_TEXT, c, 1'b0};
                n++;
                lex_state = nbl_pkg::MODE_WORD;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) begin
                tok[i].last = 1'b1;
            end
            pending_tokens.push_back(tok[i]);
        end
    endfunction

    // ---------------------------------------------------------------- sending side

    // Called and returning at a falling edge; one request per call.
    task automatic send_item(input logic [7:0] c, input logic at_end);
        int gap;
        gap = 0;
        if (idle_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            i_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= c;
        i_tlast  <= at_end;
        @(posedge i_clk);
        while (!o_tready) @(posedge i_clk);
        lex_predict(c, at_end);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_buf();
        while (text_buf.size() != 0) begin
            send_item(text_buf.pop_front(), 1'b0);
        end
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ---------------------------------------------------------------- text builders

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endfunction

    function automatic void put_kw(input int k, input int n, input logic lower);
        for (int j = 0; j < n; j++) begin
            text_buf.push_back(lower ? (nbl_pkg::KW_TEXT[k][j] | 8'h20)
                                     : nbl_pkg::KW_TEXT[k][j]);
        end
    endfunction

    function automatic logic [7:0] any_word_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == nbl_pkg::CH_SPACE || b == nbl_pkg::CH_TAB || b == nbl_pkg::CH_NL ||
                   b == nbl_pkg::CH_HASH || b == nbl_pkg::CH_EQUAL ||
                   b == nbl_pkg::CH_LPAREN || b == nbl_pkg::CH_RPAREN ||
                   b == nbl_pkg::CH_COMMA);
        return b;
    endfunction

    function automatic logic [7:0] name_byte();
        int r;
        r = $urandom_range(0, 37);
        if (r < 26) begin
            return 8'(8'h41 + r);
        end else if (r < 36) begin
            return 8'(8'h30 + (r - 26));
        end
        return (r == 36) ? 8'h5F : any_word_byte();
    endfunction

    function automatic void put_blank();
        repeat ($urandom_range(0, 2)) begin
            text_buf.push_back($urandom_range(0, 3) == 0 ? nbl_pkg::CH_TAB
                                                         : nbl_pkg::CH_SPACE);
        end
    endfunction

    function automatic void put_ident();
        int k;
        k = $urandom_range(0, nbl_pkg::NUM_KW - 1);
        case ($urandom_range(0, 9)) inside
            [0:2]: begin
                text_buf.push_back("G");
                repeat ($urandom_range(1, 4)) begin
                    text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
            end
            [3:4]: put_kw(k, int'(nbl_pkg::KW_LEN[k]), 1'b0);
            5: put_kw(k, $urandom_range(1, nbl_pkg::KW_LEN[k] - 1), 1'b0);
            6: begin
                put_kw(k, int'(nbl_pkg::KW_LEN[k]), 1'b0);
                text_buf.push_back(name_byte());
            end
            7: repeat ($urandom_range(6, 12)) text_buf.push_back(name_byte());
            8: text_buf.push_back(any_word_byte());
            default: put_kw(k, int'(nbl_pkg::KW_LEN[k]), 1'b1);
        endcase
    endfunction

    function automatic void put_comment_body();
        logic [7:0] b;
        repeat ($urandom_range(0, 8)) begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b == nbl_pkg::CH_NL);
            text_buf.push_back(b);
        end
    endfunction

    function automatic void put_line();
        int n_args;
        case ($urandom_range(0, 9))
            0: begin
                put_str("INPUT(");
                put_ident();
                put_str(")\n");
            end
            1: begin
                put_str("OUTPUT(");
                put_ident();
                put_str(")\n");
            end
            2: begin
                text_buf.push_back(nbl_pkg::CH_HASH);
                put_comment_body();
                text_buf.push_back(nbl_pkg::CH_NL);
            end
            3: begin
                put_blank();
                text_buf.push_back(nbl_pkg::CH_NL);
            end
            default: begin
                put_ident();
                put_blank();
                text_buf.push_back(nbl_pkg::CH_EQUAL);
                put_blank();
                if ($urandom_range(0, 4) != 0) begin
                    n_args = $urandom_range(0, nbl_pkg::NUM_KW - 1);
                    put_kw(n_args, int'(nbl_pkg::KW_LEN[n_args]), 1'b0);
                end else begin
                    put_ident();
                end
                text_buf.push_back(nbl_pkg::CH_LPAREN);
                n_args = $urandom_range(1, 3);
                for (int i = 0; i < n_args; i++) begin
                    if (i > 0) begin
                        text_buf.push_back(nbl_pkg::CH_COMMA);
                        put_blank();
                    end
                    put_ident();
                end
                text_buf.push_back(nbl_pkg::CH_RPAREN);
                if ($urandom_range(0, 5) == 0) begin
                    put_blank();
                    text_buf.push_back(nbl_pkg::CH_HASH);
                    put_comment_body();
                end
                text_buf.push_back(nbl_pkg::CH_NL);
            end
        endcase
    endfunction

    // Garbage: raw bytes, stray delimiters, a word cut by '#', or an open comment.
    function automatic void put_noise();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
            1: repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(nbl_pkg::CH_EQUAL);
                    1: text_buf.push_back(nbl_pkg::CH_LPAREN);
                    2: text_buf.push_back(nbl_pkg::CH_RPAREN);
                    default: text_buf.push_back(nbl_pkg::CH_COMMA);
                endcase
            end
            2: begin
                put_ident();
                text_buf.push_back(nbl_pkg::CH_HASH);
                put_comment_body();
                text_buf.push_back(nbl_pkg::CH_NL);
            end
            default: begin
                text_buf.push_back(nbl_pkg::CH_HASH);
                put_comment_body();
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_comment_and_blank();
        send_str("#c\n\t");
    endtask

    task automatic test_word_closing();
        send_str("INV(");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_str(")=a#\n");
    endtask

    task automatic test_end_marker();
        send_str("OR");
        send_end();
        send_end();
        send_str("#");
        send_end();
    endtask

    task automatic test_random_netlist(input int n_items);
        int goal;
        int r;
        goal = n_sent + n_items;
        while (n_sent < goal) begin
            if ($urandom_range(0, 39) == 0) begin
                idle_gaps = !idle_gaps;
            end
            r = $urandom_range(0, 19);
            if (r < 16) begin
                put_line();
            end else if (r < 19) begin
                put_noise();
            end
            send_buf();
            if (r == 19 || (r >= 16 && $urandom_range(0, 2) == 0)) begin
                send_end();
            end
        end
    endtask

    // The receiver holds off while two-result characters keep coming, so the
    // result queue fills and the lexer must stop taking input.
    task automatic test_output_stall();
        idle_gaps = 1'b0;
        long_hold = 1'b1;
        repeat (16) begin
            put_ident();
            text_buf.push_back(nbl_pkg::CH_COMMA);
        end
        send_buf();
        send_end();
        idle_gaps = 1'b1;
    endtask

    task automatic test_steady_stream(input int n_items);
        int goal;
        idle_gaps = 1'b0;
        goal = n_sent + n_items;
        while (n_sent < goal) begin
            put_line();
            send_buf();
        end
        send_end();
    endtask

    // ---------------------------------------------------------------- receiving side

    initial begin
        i_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (idle_gaps && $urandom_range(0, 7) == 0) begin
                i_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                i_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : token_check
        nbl_pkg::t_result want;
        if (i_rst_n && o_tvalid && i_tready) begin
            n_checked++;
            if (pending_tokens.size() == 0) begin
                $error("token_kind %0d text_byte %0h arrived with nothing expected",
                       o_tuser, o_tdata);
                n_errors++;
            end else begin
                want = pending_tokens.pop_front();
                if (o_tuser != want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_tuser);
                    n_errors++;
                end
                if (o_tdata != want.text) begin
                    $error("text_byte: expected %0h, got %0h", want.text, o_tdata);
                    n_errors++;
                end
                if (o_tlast != want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_tlast);
                    n_errors++;
                end
                if (want.kind == nbl_pkg::KIND_EOF) begin
                    n_eof++;
                end else if (want.kind > nbl_pkg::KIND_COMMA &&
                             want.kind < nbl_pkg::KIND_NAME) begin
                    n_keywords++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n   = 1'b0;
        i_tvalid  = 1'b0;
        i_tdata   = 8'h00;
        i_tlast   = 1'b0;
        idle_gaps = 1'b1;
        long_hold = 1'b0;
        lex_state = nbl_pkg::MODE_IDLE;
        kw_live   = nbl_pkg::ALIVE_ALL;
        word_len  = 3'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_comment_and_blank();
        test_word_closing();
        test_end_marker();
        test_random_netlist(1450);
        test_output_stall();
        test_steady_stream(150);

        i_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", pending_tokens.size());
            n_errors++;
        end

        $display("Lexed %0d characters and end markers; checked %0d tokens,", n_sent,
                 n_checked);
        $display("among them %0d keywords and %0d end-of-file tokens.", n_keywords, n_eof);
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #(8 * LIMIT_CYCLES);
        $display("testbench: done, errors");
        $finish;
    end

endmodule

### netlist_bench_lexer.f
sv/nbl_pkg.sv
sv/nbl_core.sv
sv/nbl_res_fifo.sv
sv/netlist_bench_lexer.sv
dv/testbench.sv
